// ===== rtl/text_console_writer_defines.svh =====
// ----------------------------------------------------------------------------
// text console writer assertion macros
// shared concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TCW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// text console writer package
// field widths, codes, command and state types shared by the console blocks
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int CELL_W  = 16;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int ATTR_W  = 8;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] LINE_FEED       = 8'd10;
  localparam logic [CHAR_W-1:0] CARRIAGE_RETURN = 8'd13;

  // black-on-black space
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_LF,
    OP_CR,
    OP_READ,
    OP_ZERO,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } cmd_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_CLEAR,
    S_RESULT
  } back_state_e;

endpackage

// ===== rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// tcw command queue
// two-entry fifo of classified commands between front and back
// ----------------------------------------------------------------------------
module tcw_queue
  import tcw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic empty_o
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  cmd_t            entry_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [PW:0]     count_q, count_d;

  assign full_o    = (count_q == (PW+1)'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw front end
// accepts input items and turns them into engine commands
// ----------------------------------------------------------------------------
module tcw_front
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [INDEX_W-1:0] cell_index_i,
  input  logic               queue_full_i,
  input  logic               init_busy_i,
  output logic               push_o,
  output cmd_t               push_cmd_o
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int IXW = (INDEX_W > $clog2(CELL_COUNT + 1)) ? INDEX_W : $clog2(CELL_COUNT + 1);

  logic in_range;
  op_e  op;

  assign in_range = (IXW'(cell_index_i) < IXW'(CELL_COUNT));

  always_comb begin
    case (mode_i)
      MODE_WRITE: begin
        if (char_code_i == LINE_FEED) begin
          op = OP_LF;
        end else if (char_code_i == CARRIAGE_RETURN) begin
          op = OP_CR;
        end else begin
          op = OP_PUT;
        end
      end
      MODE_READ:  op = in_range ? OP_READ : OP_ZERO;
      MODE_CLEAR: op = OP_CLEAR;
      default:    op = OP_ZERO;
    endcase
  end

  // nothing enters while the store is being blanked after reset
  assign in_stall_o = queue_full_i || init_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  assign push_cmd_o.op         = op;
  assign push_cmd_o.char_code  = char_code_i;
  assign push_cmd_o.cell_index = cell_index_i;

endmodule

// ===== rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw back end
// cursor, cell store sequencing (write, read, scroll, blank) and result register
// ----------------------------------------------------------------------------
module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ATTR_W-1:0] text_attribute_i,
  input  logic              queue_empty_i,
  input  cmd_t              queue_cmd_i,
  output logic              pop_o,
  output logic              init_busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CELL_W-1:0] cell_value_o,
  output logic [COL_W-1:0]  cursor_column_o,
  output logic [ROW_W-1:0]  cursor_row_o
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int MOVE_COUNT = COLUMNS * (ROWS - 1);
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int XW         = (AW > COL_W) ? AW : COL_W;
  localparam int LAST_COL   = COLUMNS - 1;
  localparam int LAST_ROW   = ROWS - 1;

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [AW-1:0]     base_q, base_d;
  logic [CELL_W-1:0] value_q, value_d;
  logic              out_valid_q, out_valid_d;
  logic [CELL_W-1:0] out_value_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;

  logic              newline;
  logic              load;
  logic              out_free;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    col_d     = col_q;
    row_d     = row_q;
    base_d    = base_q;
    value_d   = value_q;
    newline   = 1'b0;
    load      = 1'b0;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = BLANK_CELL;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_INIT, S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt_q);
        if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_RESULT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (!queue_empty_i) begin
          pop_o   = 1'b1;
          value_d = '0;
          state_d = S_RESULT;
          case (queue_cmd_i.op)
            OP_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = AW'(XW'(base_q) + XW'(col_q));
              ram_wdata = {text_attribute_i, queue_cmd_i.char_code};
              if (col_q == COL_W'(LAST_COL)) begin
                col_d   = '0;
                newline = 1'b1;
              end else begin
                col_d = col_q + 1'b1;
              end
            end
            OP_LF: begin
              col_d   = '0;
              newline = 1'b1;
            end
            OP_CR: begin
              col_d = '0;
            end
            OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = AW'(queue_cmd_i.cell_index);
              state_d   = S_READ;
            end
            OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              base_d  = '0;
              cnt_d   = '0;
              state_d = S_CLEAR;
            end
            default: ;
          endcase
          // moving past the last row scrolls and keeps the cursor there
          if (newline) begin
            if (row_q == ROW_W'(LAST_ROW)) begin
              cnt_d   = '0;
              state_d = S_SCROLL;
            end else begin
              row_d  = row_q + 1'b1;
              base_d = base_q + AW'(COLUMNS);
            end
          end
        end
      end
      S_READ: begin
        value_d = ram_rdata;
        state_d = S_RESULT;
      end
      S_SCROLL: begin
        // read one row ahead, write the previous read one cell behind
        if (cnt_q < CNT_W'(MOVE_COUNT)) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(cnt_q + CNT_W'(COLUMNS));
        end
        if (cnt_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(cnt_q - 1'b1);
          ram_wdata = (cnt_q <= CNT_W'(MOVE_COUNT)) ? ram_rdata : BLANK_CELL;
        end
        if (cnt_q == CNT_W'(CELL_COUNT)) begin
          cnt_d   = '0;
          state_d = S_RESULT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (load) begin
      out_value_q <= value_q;
      out_col_q   <= col_q;
      out_row_q   <= row_q;
    end
  end

  assign init_busy_o     = (state_q == S_INIT);
  assign out_valid_o     = out_valid_q;
  assign cell_value_o    = out_value_q;
  assign cursor_column_o = out_col_q;
  assign cursor_row_o    = out_row_q;

endmodule

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text console writer
// text-mode console engine: cell grid, cursor, scroll, clear and cell read
// ----------------------------------------------------------------------------
// A front end classifies each input transfer and queues it (two entries), so
// the input keeps moving while the engine works. The engine owns a
// ROWS*COLUMNS x 16 cell store with one write and one read port. A scroll
// moves the store and a clear blanks it, one cell per cycle through its
// single write port. After reset the input stalls while the store is blanked;
// attribute writes are taken at any time. Each result waits in an output
// register until transferred.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ATTR_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [INDEX_W-1:0] cell_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CELL_W-1:0]  cell_value_o,
  output logic [COL_W-1:0]   cursor_column_o,
  output logic [ROW_W-1:0]   cursor_row_o
);

  logic [ATTR_W-1:0] text_attribute_q;
  logic              push;
  cmd_t              push_cmd;
  logic              queue_full;
  logic              queue_empty;
  logic              pop;
  cmd_t              pop_cmd;
  logic              init_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attribute_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      text_attribute_q <= cfg_wdata_i;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .queue_full_i (queue_full),
    .init_busy_i  (init_busy),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  tcw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (queue_full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (queue_empty)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .text_attribute_i (text_attribute_q),
    .queue_empty_i    (queue_empty),
    .queue_cmd_i      (pop_cmd),
    .pop_o            (pop),
    .init_busy_o      (init_busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cell_value_o     (cell_value_o),
    .cursor_column_o  (cursor_column_o),
    .cursor_row_o     (cursor_row_o)
  );

endmodule

// ===== rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw port checker
// port-level assertions on the text console writer, attached by bind
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CELL_W-1:0] cell_value_o,
  input logic [COL_W-1:0]  cursor_column_o,
  input logic [ROW_W-1:0]  cursor_row_o
);

  `TCW_ASSERT_IMPLY(a_col_in_grid, out_valid_o, cursor_column_o < COLUMNS, "cursor column off grid")
  `TCW_ASSERT_IMPLY(a_row_in_grid, out_valid_o, cursor_row_o < ROWS, "cursor row off grid")
  `TCW_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(cell_value_o) && $stable(cursor_column_o) && $stable(cursor_row_o), "stalled result changed")
  // the store is still being blanked right after reset
  `TCW_ASSERT_IMPLY(a_init_stall, !$past(rst_ni), in_stall_o, "input taken during store blanking")

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .cell_value_o    (cell_value_o),
  .cursor_column_o (cursor_column_o),
  .cursor_row_o    (cursor_row_o)
);

// ===== tb/sv/tb_text_console_writer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text console writer testbench
// drives write, read, clear and unused-mode items through the console engine
// with random idling on both sides, tracks the cell grid and cursor in a
// shadow copy and checks every result transfer field by field
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int GRID_COLS     = 80;
  localparam int GRID_ROWS     = 25;
  localparam int CELL_TOTAL    = GRID_COLS * GRID_ROWS;
  localparam int IDLE_PCT      = 25;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 144;
  localparam int DRAIN_CYCLES  = 32;

  // mode code the block must ignore
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } console_cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
  } console_view_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [ATTR_W-1:0]  cfg_wdata_i     = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [MODE_W-1:0]  mode_i          = '0;
  logic [CHAR_W-1:0]  char_code_i     = '0;
  logic [INDEX_W-1:0] cell_index_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [CELL_W-1:0]  cell_value_o;
  logic [COL_W-1:0]   cursor_column_o;
  logic [ROW_W-1:0]   cursor_row_o;

  text_console_writer #(
    .COLUMNS(GRID_COLS),
    .ROWS   (GRID_ROWS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .char_code_i    (char_code_i),
    .cell_index_i   (cell_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_value_o   (cell_value_o),
    .cursor_column_o(cursor_column_o),
    .cursor_row_o   (cursor_row_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow console state
  logic [CELL_W-1:0] shadow_cells [CELL_TOTAL];
  logic [ATTR_W-1:0] shadow_attr;
  int                cur_col;
  int                cur_row;

  console_cmd_t  pending_cmds [$];
  console_view_t expected_views [$];
  console_cmd_t  drive_cmd;
  console_view_t want_view;
  bit            quiet_phase = 1'b0;
  int            fail_count  = 0;

  function automatic void blank_grid();
    for (int i = 0; i < CELL_TOTAL; i++) shadow_cells[i] = BLANK_CELL;
  endfunction

  function automatic console_view_t console_step(console_cmd_t c);
    console_view_t v;
    int            where;
    v.cell_value = '0;
    case (c.mode)
      MODE_WRITE: begin
        if (c.char_code == LINE_FEED) begin
          cur_col = 0;
          cur_row++;
        end else if (c.char_code == CARRIAGE_RETURN) begin
          cur_col = 0;
        end else begin
          where = cur_row * GRID_COLS + cur_col;
          shadow_cells[where] = {shadow_attr, c.char_code};
          cur_col++;
          // column wrap
          if (cur_col >= GRID_COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // scroll up one row, blank the last one
        if (cur_row >= GRID_ROWS) begin
          for (int i = 0; i < CELL_TOTAL - GRID_COLS; i++)
            shadow_cells[i] = shadow_cells[i + GRID_COLS];
          for (int i = CELL_TOTAL - GRID_COLS; i < CELL_TOTAL; i++)
            shadow_cells[i] = BLANK_CELL;
          cur_row = GRID_ROWS - 1;
        end
      end
      MODE_READ: begin
        if (c.cell_index < CELL_TOTAL) v.cell_value = shadow_cells[c.cell_index];
      end
      MODE_CLEAR: begin
        blank_grid();
        cur_col = 0;
        cur_row = 0;
      end
      default: ;
    endcase
    v.cursor_column = cur_col[COL_W-1:0];
    v.cursor_row    = cur_row[ROW_W-1:0];
    return v;
  endfunction

  function automatic console_cmd_t random_cmd(int lf_pct, int clear_pct);
    console_cmd_t c;
    int           pick;
    int           sub;
    pick         = $urandom_range(99);
    sub          = $urandom_range(99);
    c.mode       = MODE_WRITE;
    c.char_code  = CHAR_W'($urandom_range(255));
    c.cell_index = INDEX_W'($urandom_range(2047));
    if (pick < 20) begin
      c.mode = MODE_READ;
      // bias some reads toward the top rows and the scrolled last row
      if (sub < 25)
        c.cell_index = INDEX_W'(CELL_TOTAL - GRID_COLS + $urandom_range(GRID_COLS - 1));
      else if (sub < 50) c.cell_index = INDEX_W'($urandom_range(2 * GRID_COLS - 1));
    end else if (pick < 20 + clear_pct) begin
      c.mode = MODE_CLEAR;
    end else if (pick < 23 + clear_pct) begin
      c.mode = MODE_UNUSED;
    end else if (sub < lf_pct) begin
      c.char_code = LINE_FEED;
    end else if (sub < lf_pct + 3) begin
      c.char_code = CARRIAGE_RETURN;
    end
    return c;
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i) expected_views.push_back(console_step(drive_cmd));
      if (pending_cmds.size() != 0 && (quiet_phase || $urandom_range(99) >= IDLE_PCT)) begin
        drive_cmd    = pending_cmds.pop_front();
        in_valid_i   <= 1'b1;
        mode_i       <= drive_cmd.mode;
        char_code_i  <= drive_cmd.char_code;
        cell_index_i <= drive_cmd.cell_index;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= !quiet_phase && ($urandom_range(99) < IDLE_PCT);
      if (out_valid_o && !out_stall_i) begin
        if (expected_views.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          want_view = expected_views.pop_front();
          if (cell_value_o !== want_view.cell_value) begin
            $error("cell_value expected %h actual %h", want_view.cell_value, cell_value_o);
            fail_count++;
          end
          if (cursor_column_o !== want_view.cursor_column) begin
            $error("cursor_column expected %0d actual %0d",
                   want_view.cursor_column, cursor_column_o);
            fail_count++;
          end
          if (cursor_row_o !== want_view.cursor_row) begin
            $error("cursor_row expected %0d actual %0d", want_view.cursor_row, cursor_row_o);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_views.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_attr(logic [ATTR_W-1:0] value);
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    shadow_attr = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic console_cmd_t make_cmd(logic [MODE_W-1:0] m, logic [CHAR_W-1:0] ch,
                                            logic [INDEX_W-1:0] idx);
    console_cmd_t c;
    c.mode       = m;
    c.char_code  = ch;
    c.cell_index = idx;
    return c;
  endfunction

  initial begin
    int lf_pct;
    int clear_pct;
    blank_grid();
    cur_col     = 0;
    cur_row     = 0;
    shadow_attr = ATTR_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items under the reset attribute
    @(negedge clk_i);
    pending_cmds.push_back(make_cmd(MODE_READ,   8'h00, 11'd0));
    pending_cmds.push_back(make_cmd(MODE_WRITE,  8'h41, 11'd0));
    pending_cmds.push_back(make_cmd(MODE_WRITE,  8'h00, 11'h7ff));
    pending_cmds.push_back(make_cmd(MODE_WRITE,  8'hff, 11'd0));
    pending_cmds.push_back(make_cmd(MODE_WRITE,  CARRIAGE_RETURN, 11'd0));
    pending_cmds.push_back(make_cmd(MODE_WRITE,  8'h42, 11'd0));
    pending_cmds.push_back(make_cmd(MODE_WRITE,  LINE_FEED, 11'd0));
    pending_cmds.push_back(make_cmd(MODE_WRITE,  8'h43, 11'd0));
    pending_cmds.push_back(make_cmd(MODE_READ,   8'hff, 11'd0));
    pending_cmds.push_back(make_cmd(MODE_READ,   8'h00, 11'd1));
    pending_cmds.push_back(make_cmd(MODE_READ,   8'h00, 11'd2));
    pending_cmds.push_back(make_cmd(MODE_READ,   8'h00, 11'd80));
    pending_cmds.push_back(make_cmd(MODE_READ,   8'h00, 11'd1999));
    pending_cmds.push_back(make_cmd(MODE_READ,   8'h00, 11'd2000));
    pending_cmds.push_back(make_cmd(MODE_READ,   8'h00, 11'h7ff));
    pending_cmds.push_back(make_cmd(MODE_UNUSED, 8'hff, 11'h7ff));
    pending_cmds.push_back(make_cmd(MODE_UNUSED, LINE_FEED, 11'd0));
    pending_cmds.push_back(make_cmd(MODE_CLEAR,  8'h41, 11'd5));
    pending_cmds.push_back(make_cmd(MODE_READ,   8'h00, 11'd0));
    pending_cmds.push_back(make_cmd(MODE_WRITE,  8'h5a, 11'd0));
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) write_attr(8'hff);
      else if (p == 1) write_attr(8'h00);
      else write_attr(ATTR_W'($urandom_range(255)));
      // mix: ordinary text with clears, long lines that wrap, dense line feeds
      case (p % 3)
        0: begin lf_pct = 12; clear_pct = 2; end
        1: begin lf_pct = 1;  clear_pct = 0; end
        default: begin lf_pct = 20; clear_pct = 0; end
      endcase
      @(negedge clk_i);
      quiet_phase = (p == 4);
      for (int k = 0; k < PHASE_ITEMS; k++)
        pending_cmds.push_back(random_cmd(lf_pct, clear_pct));
      wait_drained();
    end

    quiet_phase = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
